// ----- rtl/rhit_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rhit_pkg: shared constants, types and helpers of the intern table
// Table geometry, entry layout, status codes and the hash step.
// ----------------------------------------------------------------------------
package rhit_pkg;

	// table geometry (BUCKETS and WAYS are powers of two here: the bucket
	// is the low bits of the hash and the handle is bucket*WAYS+way)
	localparam int BUCKETS     = 256;
	localparam int WAYS        = 4;
	localparam int HASH_BITS   = 32;
	localparam int COUNT_BITS  = 16;

	localparam int BUCKET_BITS = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;

	// port widths fixed by the result word
	localparam int STATUS_W    = 3;
	localparam int HANDLE_W    = 10;
	localparam int REFCNT_W    = 16;
	localparam int BYTE_W      = 8;

	localparam int HASH_SHIFT  = 5;
	localparam logic [HASH_BITS-1:0]  HASH_SEED = HASH_BITS'(5381);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [STATUS_W-1:0] {
		ST_FOUND     = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_RELEASED  = 3'd2,
		ST_REMOVED   = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic {
		OP_INTERN  = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef struct packed {
		logic                  vld;
		logic [HASH_BITS-1:0]  hash;
		logic [COUNT_BITS-1:0] cnt;
	} entry_t;

	typedef entry_t [WAYS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

	// hash*33 xor sign-extended byte
	function automatic logic [HASH_BITS-1:0] hash_step(
		input logic [HASH_BITS-1:0] h,
		input logic [BYTE_W-1:0]    b
	);
		logic [HASH_BITS-1:0] bx;
		bx = {{(HASH_BITS-BYTE_W){b[BYTE_W-1]}}, b};
		return ((h << HASH_SHIFT) + h) ^ bx;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rhit_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rhit_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with registered data held when not read.
// ----------------------------------------------------------------------------
module rhit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/refcounted_hash_intern_table_unit.sv -----
`default_nettype none
// Result: after the last byte of a string is taken, its bucket row is read,
//   then compared and written back as the result word is registered.
// Throughput: one byte per cycle while in_ready is high; a string end blocks
//   input while its bucket row is read, modified and written back, and for
//   longer while the previous result word still waits at the output.
// Reset: after arst_n releases, a clearing pass writes all BUCKETS rows
//   with in_ready low; the hash restarts at its seed.
// ----------------------------------------------------------------------------
// refcounted_hash_intern_table_unit
// Hashes byte strings and interns or releases them in a bucketed table of
// reference-counted entries kept in one row-wide RAM.
// ----------------------------------------------------------------------------
module refcounted_hash_intern_table_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          op,
	input  wire logic [rhit_pkg::BYTE_W-1:0]   data_byte,
	input  wire logic                          byte_valid,
	input  wire logic                          last,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [rhit_pkg::STATUS_W-1:0] status,
	output logic      [rhit_pkg::HANDLE_W-1:0] handle,
	output logic      [rhit_pkg::REFCNT_W-1:0] ref_count
);

	localparam int BB = rhit_pkg::BUCKET_BITS;
	localparam int WB = rhit_pkg::WAY_BITS;
	localparam int HB = rhit_pkg::HASH_BITS;
	localparam int CB = rhit_pkg::COUNT_BITS;

	// clearing pass
	logic          clr_q;
	logic [BB-1:0] clr_addr_q;

	// hash state
	logic [HB-1:0] hash_q;
	logic [HB-1:0] hash_fin;
	logic          acc;

	// lookup stage
	logic          busy_s1;
	logic          op_s1;
	logic [HB-1:0] hash_s1;
	logic [BB-1:0] bucket_s1;
	logic          fire_s1;

	// output register
	logic                        out_valid_q;
	logic [rhit_pkg::STATUS_W-1:0] status_q;
	logic [rhit_pkg::HANDLE_W-1:0] handle_q;
	logic [rhit_pkg::REFCNT_W-1:0] ref_count_q;

	// ram
	logic                       ram_wr_en;
	logic [BB-1:0]              ram_wr_addr;
	logic [rhit_pkg::ROW_W-1:0] ram_wr_data;
	logic [rhit_pkg::ROW_W-1:0] ram_rd_data;

	// row update
	rhit_pkg::row_t    row_rd;
	rhit_pkg::row_t    row_wr;
	logic              match_hit;
	logic [WB-1:0]     match_way;
	logic              free_hit;
	logic [WB-1:0]     free_way;
	logic [WB-1:0]     sel_way;
	logic [CB-1:0]     cur_cnt;
	logic [CB-1:0]     new_cnt;
	logic              row_chg;
	rhit_pkg::status_t res_status;
	logic              res_has_slot;
	logic [31:0]       slot_idx;

	assign in_ready = !clr_q && !busy_s1;
	assign acc      = in_valid && in_ready;
	assign fire_s1  = busy_s1 && (!out_valid_q || out_ready);

	assign hash_fin = byte_valid ? rhit_pkg::hash_step(hash_q, data_byte) : hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == BB'(rhit_pkg::BUCKETS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= rhit_pkg::HASH_SEED;
		end else if (acc) begin
			hash_q <= last ? rhit_pkg::HASH_SEED : hash_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (acc && last) begin
			busy_s1 <= 1'b1;
		end else if (fire_s1) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && last) begin
			op_s1     <= op;
			hash_s1   <= hash_fin;
			bucket_s1 <= hash_fin[BB-1:0];
		end
	end

	rhit_ram #(
		.WIDTH (rhit_pkg::ROW_W),
		.DEPTH (rhit_pkg::BUCKETS)
	) u_row_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (acc && last),
		.rd_addr (hash_fin[BB-1:0]),
		.rd_data (ram_rd_data)
	);

	assign row_rd = rhit_pkg::row_t'(ram_rd_data);

	// way search: lowest matching valid way, lowest free way
	always_comb begin
		match_hit = 1'b0;
		match_way = '0;
		free_hit  = 1'b0;
		free_way  = '0;
		for (int w = 0; w < rhit_pkg::WAYS; w++) begin
			if (row_rd[w].vld) begin
				if (!match_hit && row_rd[w].hash == hash_s1) begin
					match_hit = 1'b1;
					match_way = WB'(w);
				end
			end else if (!free_hit) begin
				free_hit = 1'b1;
				free_way = WB'(w);
			end
		end
	end

	always_comb begin
		row_wr       = row_rd;
		sel_way      = match_way;
		cur_cnt      = row_rd[match_way].cnt;
		new_cnt      = '0;
		row_chg      = 1'b0;
		res_has_slot = 1'b0;
		res_status   = rhit_pkg::ST_NOT_FOUND;
		if (op_s1 == rhit_pkg::OP_INTERN) begin
			if (match_hit) begin
				new_cnt                 = (cur_cnt == rhit_pkg::COUNT_MAX) ? cur_cnt
				                          : cur_cnt + 1'b1;
				row_wr[match_way].cnt   = new_cnt;
				row_chg                 = 1'b1;
				res_has_slot            = 1'b1;
				res_status              = rhit_pkg::ST_FOUND;
			end else if (free_hit) begin
				sel_way                 = free_way;
				new_cnt                 = CB'(1);
				row_wr[free_way].vld    = 1'b1;
				row_wr[free_way].hash   = hash_s1;
				row_wr[free_way].cnt    = new_cnt;
				row_chg                 = 1'b1;
				res_has_slot            = 1'b1;
				res_status              = rhit_pkg::ST_INSERTED;
			end else begin
				res_status              = rhit_pkg::ST_FULL;
			end
		end else begin
			if (match_hit) begin
				row_chg      = 1'b1;
				res_has_slot = 1'b1;
				// count of one or zero frees the way
				if (cur_cnt <= CB'(1)) begin
					row_wr[match_way] = '0;
					res_status        = rhit_pkg::ST_REMOVED;
				end else begin
					new_cnt               = cur_cnt - 1'b1;
					row_wr[match_way].cnt = new_cnt;
					res_status            = rhit_pkg::ST_RELEASED;
				end
			end
		end
	end

	assign slot_idx = 32'(bucket_s1) * 32'(rhit_pkg::WAYS) + 32'(sel_way);

	assign ram_wr_en   = clr_q || (fire_s1 && row_chg);
	assign ram_wr_addr = clr_q ? clr_addr_q : bucket_s1;
	assign ram_wr_data = clr_q ? '0 : rhit_pkg::ROW_W'(row_wr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			status_q    <= res_status;
			handle_q    <= res_has_slot ? slot_idx[rhit_pkg::HANDLE_W-1:0] : '0;
			ref_count_q <= rhit_pkg::REFCNT_W'(new_cnt);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign handle    = handle_q;
	assign ref_count = ref_count_q;

endmodule
`default_nettype wire

// ----- rtl/rhit_chk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rhit_chk: port-level checker of the intern table
// Watches result words against string ends and the status encoding.
// ----------------------------------------------------------------------------
module rhit_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          last,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [rhit_pkg::STATUS_W-1:0] status,
	input wire logic [rhit_pkg::HANDLE_W-1:0] handle,
	input wire logic [rhit_pkg::REFCNT_W-1:0] ref_count
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(handle)
		&& $stable(ref_count))
		else $error("result word changed while stalled");

	// a string end taken with an empty output slot always gives a result word
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last && !out_valid |=> ##1 out_valid)
		else $error("string end produced no result word");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == rhit_pkg::ST_FULL || status == rhit_pkg::ST_NOT_FOUND)
		|-> handle == '0 && ref_count == '0)
		else $error("miss result carries handle or count");

	a_count_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != rhit_pkg::ST_INSERTED || ref_count == 16'd1)
		&& (status != rhit_pkg::ST_REMOVED || ref_count == '0)
		&& (status != rhit_pkg::ST_RELEASED || ref_count != '0))
		else $error("count inconsistent with status");

endmodule

bind refcounted_hash_intern_table_unit rhit_chk u_rhit_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.last      (last),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.handle    (handle),
	.ref_count (ref_count)
);
`default_nettype wire
